/* src/mqtt_phi_pkg.sv */
// shared constants and result type of the mqtt packet header inspector
`timescale 1ns / 1ps
`default_nettype none
package mqtt_phi_pkg;

  localparam int BUFFER_BYTES = 4096;
  localparam int POS_W        = $clog2(BUFFER_BYTES + 1);

  localparam int TYPE_W = 4;
  localparam int RLEN_W = 28;
  localparam int QOS_W  = 2;
  localparam int KEEP_W = 16;
  localparam int NAME_W = 12;
  localparam int STR_W  = 16;
  localparam int LBS_W  = 3;

  localparam int RES_BITS = TYPE_W + 1 + RLEN_W + QOS_W + 1 + 1 + KEEP_W + NAME_W + NAME_W + 1;
  localparam int OUT_W    = ((RES_BITS + 7) / 8) * 8;

  localparam logic [TYPE_W-1:0] PKT_CONNECT   = 4'd1;
  localparam logic [TYPE_W-1:0] PKT_PUBLISH   = 4'd3;
  localparam logic [TYPE_W-1:0] PKT_SUBSCRIBE = 4'd8;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] LEN_MASK = 8'h7F;

  typedef struct packed {
    logic [TYPE_W-1:0] pkt_kind;
    logic              malformed;
    logic [RLEN_W-1:0] rem_len;
    logic [QOS_W-1:0]  qos;
    logic              retain;
    logic              will_bit;
    logic [KEEP_W-1:0] keepalive;
    logic [NAME_W-1:0] name_offset;
    logic [NAME_W-1:0] name_length;
    logic              wildcard_res;
  } result_t;

endpackage
`default_nettype wire

/* src/mqtt_phi_parser.sv */
// per-byte parser state and the result formed on the last byte of a buffer
`timescale 1ns / 1ps
`default_nettype none
module mqtt_phi_parser (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  take,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  last_byte,
  output mqtt_phi_pkg::result_t      result
);
  import mqtt_phi_pkg::*;

  typedef enum logic [15:0] {
    PH_HEADER     = 16'h0001,
    PH_LENGTH     = 16'h0002,
    PH_IDLE       = 16'h0004,
    PH_PROTO_HI   = 16'h0008,
    PH_PROTO_LO   = 16'h0010,
    PH_PROTO_BODY = 16'h0020,
    PH_CONN_FIXED = 16'h0040,
    PH_NAME_HI    = 16'h0080,
    PH_NAME_LO    = 16'h0100,
    PH_NAME_BODY  = 16'h0200,
    PH_NAME_DONE  = 16'h0400,
    PH_PKT_ID     = 16'h0800,
    PH_FILT_HI    = 16'h1000,
    PH_FILT_LO    = 16'h2000,
    PH_FILT_BODY  = 16'h4000,
    PH_FILT_QOS   = 16'h8000
  } phase_t;

  typedef enum logic [2:0] {
    LS_DECODING = 3'b001,
    LS_VALID    = 3'b010,
    LS_FAILED   = 3'b100
  } len_status_t;

  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [7:0]        first_header_byte, first_header_byte_next;
  logic [RLEN_W-1:0] length_accumulator, length_accumulator_next;
  logic [LBS_W-1:0]  length_bytes_seen, length_bytes_seen_next;
  len_status_t       length_status, length_status_next;
  phase_t            parse_phase, parse_phase_next;
  logic [STR_W-1:0]  field_countdown, field_countdown_next;
  logic [NAME_W-1:0] string_start, string_start_next;
  logic [STR_W-1:0]  string_size, string_size_next;
  logic              connect_will, connect_will_next;
  logic [KEEP_W-1:0] keepalive_value, keepalive_value_next;
  logic              wildcard_seen, wildcard_seen_next;

  logic [TYPE_W-1:0] cur_type;
  logic [RLEN_W-1:0] len_part;
  logic [STR_W-1:0]  size_joined;
  logic [STR_W-1:0]  count_dec;
  logic              in_range;
  logic [TYPE_W-1:0] res_type;
  logic [RLEN_W:0]   need_bytes;
  logic              fixed_reached;

  assign cur_type  = first_header_byte[7:4];
  assign in_range  = (byte_position < POS_W'(BUFFER_BYTES));
  assign count_dec = field_countdown - STR_W'(1);
  assign size_joined = {string_size[7:0], data_byte};

  // seven payload bits of a length byte, placed by its index
  always_comb begin
    case (length_bytes_seen[1:0])
      2'd0:    len_part = {21'b0, data_byte[6:0]};
      2'd1:    len_part = {14'b0, data_byte[6:0], 7'b0};
      2'd2:    len_part = {7'b0, data_byte[6:0], 14'b0};
      default: len_part = {data_byte[6:0], 21'b0};
    endcase
  end

  always_comb begin
    byte_position_next      = byte_position;
    first_header_byte_next  = first_header_byte;
    length_accumulator_next = length_accumulator;
    length_bytes_seen_next  = length_bytes_seen;
    length_status_next      = length_status;
    parse_phase_next        = parse_phase;
    field_countdown_next    = field_countdown;
    string_start_next       = string_start;
    string_size_next        = string_size;
    connect_will_next       = connect_will;
    keepalive_value_next    = keepalive_value;
    wildcard_seen_next      = wildcard_seen;
    if (in_range) begin
      byte_position_next = byte_position + POS_W'(1);
      unique case (parse_phase)
        PH_HEADER: begin
          first_header_byte_next = data_byte;
          parse_phase_next       = PH_LENGTH;
        end
        PH_LENGTH: begin
          length_accumulator_next = length_accumulator | len_part;
          length_bytes_seen_next  = length_bytes_seen + LBS_W'(1);
          if (data_byte[7] == 1'b0) begin
            length_status_next = LS_VALID;
            if (cur_type == PKT_CONNECT) begin
              parse_phase_next = PH_PROTO_HI;
            end else if (cur_type == PKT_PUBLISH) begin
              parse_phase_next = PH_NAME_HI;
            end else if (cur_type == PKT_SUBSCRIBE) begin
              field_countdown_next = STR_W'(2);
              parse_phase_next     = PH_PKT_ID;
            end else begin
              parse_phase_next = PH_IDLE;
            end
          end else if (length_bytes_seen_next >= LBS_W'(4)) begin
            length_status_next = LS_FAILED;
            parse_phase_next   = PH_IDLE;
          end
        end
        PH_PROTO_HI: begin
          string_size_next = {8'b0, data_byte};
          parse_phase_next = PH_PROTO_LO;
        end
        PH_NAME_HI: begin
          string_size_next = {8'b0, data_byte};
          parse_phase_next = PH_NAME_LO;
        end
        PH_FILT_HI: begin
          string_size_next = {8'b0, data_byte};
          parse_phase_next = PH_FILT_LO;
        end
        PH_PROTO_LO: begin
          string_size_next     = size_joined;
          string_start_next    = byte_position[NAME_W-1:0] + NAME_W'(1);
          field_countdown_next = size_joined;
          if (size_joined != '0) begin
            parse_phase_next = PH_PROTO_BODY;
          end else begin
            field_countdown_next = STR_W'(4);
            parse_phase_next     = PH_CONN_FIXED;
          end
        end
        PH_NAME_LO: begin
          string_size_next     = size_joined;
          string_start_next    = byte_position[NAME_W-1:0] + NAME_W'(1);
          field_countdown_next = size_joined;
          parse_phase_next     = (size_joined != '0) ? PH_NAME_BODY : PH_NAME_DONE;
        end
        PH_FILT_LO: begin
          string_size_next     = size_joined;
          string_start_next    = byte_position[NAME_W-1:0] + NAME_W'(1);
          field_countdown_next = size_joined;
          parse_phase_next     = (size_joined != '0) ? PH_FILT_BODY : PH_FILT_QOS;
        end
        PH_PROTO_BODY: begin
          field_countdown_next = count_dec;
          if (count_dec == '0) begin
            field_countdown_next = STR_W'(4);
            parse_phase_next     = PH_CONN_FIXED;
          end
        end
        PH_CONN_FIXED: begin
          // connect flags, keepalive high, keepalive low follow the level byte
          if (field_countdown == STR_W'(3)) begin
            connect_will_next = data_byte[2];
          end else if (field_countdown == STR_W'(2)) begin
            keepalive_value_next = {data_byte, 8'b0};
          end else if (field_countdown == STR_W'(1)) begin
            keepalive_value_next = {keepalive_value[15:8], data_byte};
          end
          field_countdown_next = count_dec;
          if (count_dec == '0) begin
            parse_phase_next = PH_NAME_HI;
          end
        end
        PH_NAME_BODY: begin
          field_countdown_next = count_dec;
          if (count_dec == '0) begin
            parse_phase_next = PH_NAME_DONE;
          end
        end
        PH_PKT_ID: begin
          field_countdown_next = count_dec;
          if (count_dec == '0) begin
            parse_phase_next = PH_FILT_HI;
          end
        end
        PH_FILT_BODY: begin
          if (data_byte == CH_HASH || data_byte == CH_PLUS) begin
            wildcard_seen_next = 1'b1;
          end
          field_countdown_next = count_dec;
          if (count_dec == '0) begin
            parse_phase_next = (wildcard_seen || data_byte == CH_HASH ||
                                data_byte == CH_PLUS) ? PH_IDLE : PH_FILT_QOS;
          end
        end
        PH_FILT_QOS: begin
          parse_phase_next = PH_FILT_HI;
        end
        PH_IDLE, PH_NAME_DONE: begin
          parse_phase_next = parse_phase;
        end
        default: begin
          parse_phase_next = parse_phase;
        end
      endcase
    end
  end

  // result seen from the state after the last byte
  assign res_type   = first_header_byte_next[7:4];
  assign need_bytes = (RLEN_W+1)'(1) + (RLEN_W+1)'(length_bytes_seen_next) +
                      {1'b0, length_accumulator_next};
  assign fixed_reached = (parse_phase_next == PH_NAME_HI) || (parse_phase_next == PH_NAME_LO) ||
                         (parse_phase_next == PH_NAME_BODY) || (parse_phase_next == PH_NAME_DONE);

  always_comb begin
    result           = '0;
    result.pkt_kind  = res_type;
    result.malformed = (length_status_next != LS_VALID) ||
                       (need_bytes > (RLEN_W+1)'(byte_position_next));
    result.rem_len   = length_accumulator_next;
    if (res_type == PKT_CONNECT && fixed_reached) begin
      result.will_bit  = connect_will_next;
      result.keepalive = keepalive_value_next;
    end
    if (res_type == PKT_PUBLISH) begin
      result.qos    = first_header_byte_next[2:1];
      result.retain = first_header_byte_next[0];
    end
    if (res_type == PKT_SUBSCRIBE) begin
      result.wildcard_res = wildcard_seen_next && (parse_phase_next != PH_FILT_BODY);
    end
    if ((res_type == PKT_CONNECT || res_type == PKT_PUBLISH) &&
        parse_phase_next == PH_NAME_DONE && string_size_next != '0) begin
      result.name_offset = string_start_next;
      result.name_length = string_size_next[NAME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      byte_position      <= '0;
      first_header_byte  <= '0;
      length_accumulator <= '0;
      length_bytes_seen  <= '0;
      length_status      <= LS_DECODING;
      parse_phase        <= PH_HEADER;
      field_countdown    <= '0;
      string_start       <= '0;
      string_size        <= '0;
      connect_will       <= 1'b0;
      keepalive_value    <= '0;
      wildcard_seen      <= 1'b0;
    end else if (take) begin
      byte_position      <= byte_position_next;
      first_header_byte  <= first_header_byte_next;
      length_accumulator <= length_accumulator_next;
      length_bytes_seen  <= length_bytes_seen_next;
      length_status      <= length_status_next;
      parse_phase        <= parse_phase_next;
      field_countdown    <= field_countdown_next;
      string_start       <= string_start_next;
      string_size        <= string_size_next;
      connect_will       <= connect_will_next;
      keepalive_value    <= keepalive_value_next;
      wildcard_seen      <= wildcard_seen_next;
    end
  end

`ifndef SYNTH
  a_new_buffer: assert property (@(posedge clk) disable iff (rst)
    take && last_byte |=> parse_phase == PH_HEADER && byte_position == '0)
    else $error("parser did not restart after last byte");
  a_fail_idle: assert property (@(posedge clk) disable iff (rst)
    length_status == LS_FAILED |-> parse_phase == PH_IDLE)
    else $error("body parsed after failed length decode");
  a_len_bytes: assert property (@(posedge clk) disable iff (rst)
    length_bytes_seen <= LBS_W'(4) && byte_position <= POS_W'(BUFFER_BYTES))
    else $error("length byte count or position out of range");
`endif

endmodule
`default_nettype wire

/* src/mqtt_phi_outreg.sv */
// result register on the master side of the stream
`timescale 1ns / 1ps
`default_nettype none
module mqtt_phi_outreg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              load,
  input  wire mqtt_phi_pkg::result_t             result,
  output logic                                   ready,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [mqtt_phi_pkg::OUT_W-1:0]         m_tdata
);
  import mqtt_phi_pkg::*;

  result_t res_q;

  // register may load when empty or while its content is taken
  assign ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ready) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      res_q <= result;
    end
  end

  assign m_tdata = {{(OUT_W - RES_BITS){1'b0}},
                    res_q.wildcard_res, res_q.name_length, res_q.name_offset,
                    res_q.keepalive, res_q.will_bit, res_q.retain, res_q.qos,
                    res_q.rem_len, res_q.malformed, res_q.pkt_kind};

endmodule
`default_nettype wire

/* src/mqtt_packet_header_inspector.sv */
// top level: input register, byte parser and result register
// a last byte is held in the input register, then its result goes to the result register
// throughput: one byte per cycle; a last byte waits only while the result register
// is full and m_tready is low
// the parser state is one set of registers updated once per byte
// reset (rst, synchronous) empties both registers and returns the parser to the header byte
`timescale 1ns / 1ps
`default_nettype none
module mqtt_packet_header_inspector (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [7:0]                        s_tdata,  // data_byte
  input  wire logic                              s_tlast,  // last_byte
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // pkt_kind, malformed, rem_len, qos, retain, will_bit,
  // keepalive, name_offset, name_length, wildcard_res, zero fill
  output logic [mqtt_phi_pkg::OUT_W-1:0]         m_tdata
);
  import mqtt_phi_pkg::*;

  logic       in_vld;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_ready;
  logic       advance;
  result_t    result;

  // a non-final byte never needs the result register
  assign advance  = in_vld && (!in_last || out_ready);
  assign s_tready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  mqtt_phi_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (advance),
    .data_byte (in_byte),
    .last_byte (in_last),
    .result    (result)
  );

  mqtt_phi_outreg u_outreg (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && in_last),
    .result   (result),
    .ready    (out_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

/* tb/mqtt_packet_header_inspector_tb.sv */
// self-checking testbench for the mqtt packet header inspector
`timescale 1ns / 1ps
module mqtt_packet_header_inspector_tb;
  import mqtt_phi_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 1110;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 8;

  // parser steps of the prediction, in the order the header is walked
  typedef enum logic [3:0] {
    ST_TYPE, ST_RLEN, ST_DONE, ST_PROTO_HI, ST_PROTO_LO, ST_PROTO_STR, ST_CONN_FLAGS,
    ST_ID_HI, ST_ID_LO, ST_ID_STR, ST_ID_END, ST_PKT_ID, ST_TOPIC_HI, ST_TOPIC_LO,
    ST_TOPIC_STR, ST_TOPIC_QOS
  } hdr_step_t;

  typedef enum logic [1:0] {RL_PENDING, RL_GOOD, RL_BROKEN} rlen_state_t;

  typedef enum int {
    FR_CONNECT, FR_PUBLISH, FR_SUBSCRIBE, FR_OTHER, FR_NOISE, FR_LONG_RLEN
  } frame_kind_t;

  typedef struct {
    int      n;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = 8'h00;
  logic             s_tlast = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  mqtt_packet_header_inspector dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // predicted inspector state
  int          ins_pos;
  logic [7:0]  ins_hdr;
  logic [27:0] ins_rlen;
  int          ins_rlen_bytes;
  rlen_state_t ins_rlen_state;
  hdr_step_t   ins_step;
  logic [15:0] ins_count;
  int          ins_str_start;
  logic [15:0] ins_str_size;
  bit          ins_will;
  logic [15:0] ins_keep;
  bit          ins_wild;

  result_t predicted_headers [$];
  logic [7:0] frame_q [$];
  logic [7:0] body_q [$];

  int  mismatches = 0;
  int  results_checked = 0;
  int  bytes_sent = 0;
  int  frames_sent = 0;
  int  cycles = 0;
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;
  bit  rx_hold_req = 1'b0;

  function automatic void clear_inspector();
    ins_pos        = 0;
    ins_hdr        = '0;
    ins_rlen       = '0;
    ins_rlen_bytes = 0;
    ins_rlen_state = RL_PENDING;
    ins_step       = ST_TYPE;
    ins_count      = '0;
    ins_str_start  = 0;
    ins_str_size   = '0;
    ins_will       = 1'b0;
    ins_keep       = '0;
    ins_wild       = 1'b0;
  endfunction

  function automatic void inspect_byte(input logic [7:0] b, input bit lst,
                                       output bit done, output result_t r);
    logic [3:0] ty;
    int k;
    bit fixed_seen;
    done = 1'b0;
    r = '0;
    ty = ins_hdr[7:4];
    // bytes past the buffer size are dropped
    if (ins_pos < BUFFER_BYTES) begin
      case (ins_step)
        ST_TYPE: begin
          ins_hdr  = b;
          ins_step = ST_RLEN;
        end
        ST_RLEN: begin
          ins_rlen = ins_rlen | (28'(b[6:0]) << (7 * (ins_rlen_bytes % 4)));
          ins_rlen_bytes++;
          if (!b[7]) begin
            ins_rlen_state = RL_GOOD;
            if (ty == PKT_CONNECT) ins_step = ST_PROTO_HI;
            else if (ty == PKT_PUBLISH) ins_step = ST_ID_HI;
            else if (ty == PKT_SUBSCRIBE) begin
              ins_count = 16'd2;
              ins_step  = ST_PKT_ID;
            end else ins_step = ST_DONE;
          end else if (ins_rlen_bytes >= 4) begin
            ins_rlen_state = RL_BROKEN;
            ins_step       = ST_DONE;
          end
        end
        ST_PROTO_HI, ST_ID_HI, ST_TOPIC_HI: begin
          ins_str_size = {8'h00, b};
          ins_step     = hdr_step_t'(ins_step + 1);
        end
        ST_PROTO_LO, ST_ID_LO, ST_TOPIC_LO: begin
          ins_str_size  = {ins_str_size[7:0], b};
          ins_str_start = ins_pos + 1;
          ins_count     = ins_str_size;
          if (ins_str_size != 0) ins_step = hdr_step_t'(ins_step + 1);
          else if (ins_step == ST_PROTO_LO) begin
            ins_count = 16'd4;
            ins_step  = ST_CONN_FLAGS;
          end else if (ins_step == ST_ID_LO) ins_step = ST_ID_END;
          else ins_step = ST_TOPIC_QOS;
        end
        ST_PROTO_STR: begin
          ins_count--;
          if (ins_count == 0) begin
            ins_count = 16'd4;
            ins_step  = ST_CONN_FLAGS;
          end
        end
        ST_CONN_FLAGS: begin
          // level, flags, keepalive high, keepalive low
          k = 4 - int'(ins_count);
          if (k == 1) ins_will = b[2];
          else if (k == 2) ins_keep = {b, 8'h00};
          else if (k == 3) ins_keep[7:0] = b;
          ins_count--;
          if (ins_count == 0) ins_step = ST_ID_HI;
        end
        ST_ID_STR: begin
          ins_count--;
          if (ins_count == 0) ins_step = ST_ID_END;
        end
        ST_PKT_ID: begin
          ins_count--;
          if (ins_count == 0) ins_step = ST_TOPIC_HI;
        end
        ST_TOPIC_STR: begin
          if (b == CH_HASH || b == CH_PLUS) ins_wild = 1'b1;
          ins_count--;
          if (ins_count == 0) ins_step = ins_wild ? ST_DONE : ST_TOPIC_QOS;
        end
        ST_TOPIC_QOS: ins_step = ST_TOPIC_HI;
        default: ;
      endcase
      ins_pos++;
    end
    if (lst) begin
      ty = ins_hdr[7:4];
      r.pkt_kind  = ty;
      r.malformed = (ins_rlen_state != RL_GOOD) ||
                    (longint'(1 + ins_rlen_bytes) + longint'(ins_rlen) >
                     longint'(ins_pos));
      r.rem_len   = ins_rlen;
      if (ty == PKT_CONNECT) begin
        fixed_seen = ins_step == ST_ID_HI || ins_step == ST_ID_LO ||
                     ins_step == ST_ID_STR || ins_step == ST_ID_END;
        if (fixed_seen) begin
          r.will_bit  = ins_will;
          r.keepalive = ins_keep;
        end
      end else if (ty == PKT_PUBLISH) begin
        r.qos    = ins_hdr[2:1];
        r.retain = ins_hdr[0];
      end else if (ty == PKT_SUBSCRIBE) begin
        r.wildcard_res = ins_wild && ins_step != ST_TOPIC_STR;
      end
      if ((ty == PKT_CONNECT || ty == PKT_PUBLISH) && ins_step == ST_ID_END &&
          ins_str_size != 0) begin
        r.name_offset = ins_str_start[11:0];
        r.name_length = ins_str_size[11:0];
      end
      done = 1'b1;
      clear_inspector();
    end
  endfunction

  function automatic result_t typed_result(logic [3:0] ty, bit bad, logic [27:0] rlen,
                                           logic [1:0] q, bit ret);
    result_t r;
    r = '0;
    r.pkt_kind  = ty;
    r.malformed = bad;
    r.rem_len   = rlen;
    r.qos       = q;
    r.retain    = ret;
    return r;
  endfunction

  // one byte transfer on the input side; the gap before it is drawn per byte
  task automatic send_byte(input logic [7:0] b, input bit lst,
                           output bit done, output result_t r);
    int gap;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    inspect_byte(b, lst, done, r);
  endtask

  task automatic send_frame();
    bit done;
    result_t r;
    foreach (frame_q[i]) begin
      send_byte(frame_q[i], i == frame_q.size() - 1, done, r);
      if (done) predicted_headers = {predicted_headers, r};
    end
    frames_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (predicted_headers.size() != 0) @(posedge clk);
  endtask

  function automatic void push_rlen(int v);
    logic [7:0] b;
    do begin
      b = 8'(v & 8'h7F);
      v = v >> 7;
      if (v > 0) b[7] = 1'b1;
      frame_q = {frame_q, b};
    end while (v > 0);
  endfunction

  // length-prefixed string with an occasional wildcard character
  function automatic void push_text(int n, int wild_pct);
    body_q = {body_q, 8'(n >> 8), 8'(n)};
    repeat (n) begin
      if ($urandom_range(0, 99) < wild_pct)
        body_q = {body_q, ($urandom_range(0, 1) ? CH_HASH : CH_PLUS)};
      else if ($urandom_range(0, 7) == 0) body_q = {body_q, 8'h2F};
      else body_q = {body_q, 8'($urandom_range(8'h61, 8'h7A))};
    end
  endfunction

  function automatic void push_random(int n);
    repeat (n) body_q = {body_q, 8'($urandom_range(0, 255))};
  endfunction

  function automatic void build_frame();
    frame_kind_t kind;
    logic [3:0] ty;
    logic [3:0] flags;
    int pick, cut, idx;
    frame_q.delete();
    body_q.delete();
    pick  = $urandom_range(0, 8);
    flags = 4'($urandom_range(0, 15));
    kind  = pick < 2 ? FR_CONNECT : pick < 4 ? FR_PUBLISH : pick < 6 ? FR_SUBSCRIBE :
            pick == 6 ? FR_OTHER : pick == 7 ? FR_NOISE : FR_LONG_RLEN;
    ty = 4'($urandom_range(0, 15));
    case (kind)
      FR_CONNECT: begin
        ty = PKT_CONNECT;
        push_text($urandom_range(0, 3) == 0 ? $urandom_range(0, 6) : 4, 0);
        push_random(4);
        push_text($urandom_range(0, 12), 0);
      end
      FR_PUBLISH: begin
        ty = PKT_PUBLISH;
        push_text($urandom_range(0, 16), 5);
        if (flags[2:1] != 0) push_random(2);
        push_random($urandom_range(0, 19) == 0 ? $urandom_range(120, 200) :
                    $urandom_range(0, 8));
      end
      FR_SUBSCRIBE: begin
        ty = PKT_SUBSCRIBE;
        push_random(2);
        repeat ($urandom_range(1, 3)) begin
          push_text($urandom_range(0, 8), 10);
          push_random(1);
        end
      end
      FR_OTHER: begin
        while (ty == PKT_CONNECT || ty == PKT_PUBLISH || ty == PKT_SUBSCRIBE)
          ty = 4'($urandom_range(0, 15));
        push_random($urandom_range(0, 8));
      end
      default: ;
    endcase
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 10)) frame_q = {frame_q, 8'($urandom_range(0, 255))};
    end else if (kind == FR_LONG_RLEN) begin
      frame_q = {frame_q, 8'($urandom_range(0, 255))};
      if ($urandom_range(0, 3) == 0) frame_q = {frame_q, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
      else begin
        repeat (3) frame_q = {frame_q, 8'($urandom_range(128, 255))};
        frame_q = {frame_q, 8'($urandom_range(0, 255))};
      end
      repeat ($urandom_range(0, 4)) frame_q = {frame_q, 8'($urandom_range(0, 255))};
    end else begin
      frame_q = {frame_q, {ty, flags}};
      push_rlen(body_q.size());
      frame_q = {frame_q, body_q};
      // broken sequences: cut short, trailing junk, or one byte overwritten
      pick = $urandom_range(0, 9);
      if (pick < 2 && frame_q.size() > 1) begin
        cut = $urandom_range(1, frame_q.size() - 1);
        frame_q = frame_q[0:cut-1];
      end else if (pick == 2) begin
        repeat ($urandom_range(1, 4)) frame_q = {frame_q, 8'($urandom_range(0, 255))};
      end else if (pick == 3) begin
        idx = $urandom_range(0, frame_q.size() - 1);
        frame_q[idx] = 8'($urandom_range(0, 255));
      end
    end
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // result checking: m_tdata holds the fields from the lowest bit up
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_headers.size() == 0) begin
        $error("result transfer with no prediction pending: 0x%0h", m_tdata);
        mismatches++;
      end else begin
        want = predicted_headers.pop_front();
        results_checked++;
        check_field("pkt_kind", want.pkt_kind, m_tdata[0 +: 4]);
        check_field("malformed", want.malformed, m_tdata[4]);
        check_field("rem_len", want.rem_len, m_tdata[5 +: 28]);
        check_field("qos", want.qos, m_tdata[33 +: 2]);
        check_field("retain", want.retain, m_tdata[35]);
        check_field("will_bit", want.will_bit, m_tdata[36]);
        check_field("keepalive", want.keepalive, m_tdata[37 +: 16]);
        check_field("name_offset", want.name_offset, m_tdata[53 +: 12]);
        check_field("name_length", want.name_length, m_tdata[65 +: 12]);
        check_field("wildcard_res", want.wildcard_res, m_tdata[77]);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               predicted_headers.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stall before each transfer while rx_idle is set, one long hold-off on request
  initial begin : result_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 10) : 0;
      if (rx_hold_req) begin
        stall += LONG_HOLD;
        rx_hold_req = 1'b0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  logic [7:0] dir_bytes [0:27] = '{
    8'h3B,
    8'hF0, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h3F, 8'h80,
    8'h10, 8'h06, 8'h00, 8'h00, 8'h04, 8'h04, 8'h12, 8'h34,
    8'h82, 8'h05, 8'h00, 8'h01, 8'h00, 8'h01, 8'h23,
    8'h35, 8'h03, 8'h00, 8'h01, 8'h2B
  };
  dir_row_t dir_rows [0:5];

  initial begin : stimulus
    int bi, fi;
    bit done;
    result_t r;
    // single byte, length field that never ends, buffer ending inside the length
    dir_rows[0] = '{1, 1'b1, typed_result(PKT_PUBLISH, 1'b1, 28'd0, 2'd1, 1'b1)};
    dir_rows[1] = '{5, 1'b1, typed_result(4'hF, 1'b1, 28'hFFFFFFF, 2'd0, 1'b0)};
    dir_rows[2] = '{2, 1'b1, typed_result(PKT_PUBLISH, 1'b1, 28'd0, 2'd3, 1'b1)};
    // connect with keepalive, subscribe with a wildcard, publish topic
    dir_rows[3] = '{8, 1'b0, '0};
    dir_rows[4] = '{7, 1'b0, '0};
    dir_rows[5] = '{5, 1'b0, '0};

    clear_inspector();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    bi = 0;
    foreach (dir_rows[i]) begin
      for (int j = 0; j < dir_rows[i].n; j++) begin
        send_byte(dir_bytes[bi], j == dir_rows[i].n - 1, done, r);
        bi++;
        if (done) begin
          predicted_headers = {predicted_headers, (dir_rows[i].typed ? dir_rows[i].want : r)};
        end
      end
      frames_sent++;
    end

    fi = 0;
    while (bytes_sent < RANDOM_BYTES + bi) begin
      if (fi % 40 == 0 && fi > 0) begin
        tx_idle = $urandom_range(0, 2) != 0;
        rx_idle = $urandom_range(0, 2) != 0;
      end
      if (fi == 30) begin
        // keep offering buffers back to back while the result side holds off
        tx_idle = 1'b0;
        rx_hold_req = 1'b1;
      end
      if (fi == 55) wait_drained();
      build_frame();
      send_frame();
      fi++;
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (predicted_headers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d buffers, %0d bytes sent; %0d results checked, %0d mismatches",
             frames_sent, bytes_sent, results_checked, mismatches);
    $display("covered connect, publish, subscribe, other types, noise, broken lengths,");
    $display("truncated buffers, a full drain mid-run and a long output stall");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* mqtt_packet_header_inspector.f */
src/mqtt_phi_pkg.sv
src/mqtt_phi_parser.sv
src/mqtt_phi_outreg.sv
src/mqtt_packet_header_inspector.sv
tb/mqtt_packet_header_inspector_tb.sv
